### hdl/lnef_pkg.sv
// Shared types and constants for the line numbering and escape filter.
package lnef_pkg;

    // Input item and result item as they travel on the ports
    typedef struct packed {
        logic [7:0] in_byte;
        logic       file_start;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } result_t;

    // Configuration bits, one per register
    typedef struct packed {
        logic number_nonblank;
        logic number_all;
        logic squeeze_blank;
        logic show_ends;
        logic show_tabs;
        logic show_nonprinting;
    } cfg_t;

    // How the body of an item is written out
    typedef enum logic [1:0] {
        BODY_PLAIN  = 2'd0,
        BODY_CARET  = 2'd1,
        BODY_DOLLAR = 2'd2
    } body_kind_t;

    // Command handed from the front to the back through the queue
    typedef struct packed {
        logic       do_num;
        body_kind_t kind;
        logic [7:0] body_byte;
    } cmd_t;

    // Register indexes
    localparam logic [2:0] REG_NUMBER_NONBLANK  = 3'd0;
    localparam logic [2:0] REG_NUMBER_ALL       = 3'd1;
    localparam logic [2:0] REG_SQUEEZE_BLANK    = 3'd2;
    localparam logic [2:0] REG_SHOW_ENDS        = 3'd3;
    localparam logic [2:0] REG_SHOW_TABS        = 3'd4;
    localparam logic [2:0] REG_SHOW_NONPRINTING = 3'd5;

    // Characters
    localparam logic [7:0] CHAR_NL     = 8'h0A;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_CARET  = 8'h5E;
    localparam logic [7:0] CHAR_I      = 8'h49;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;

    // Control byte ranges
    localparam logic [7:0] CTRL_LIMIT     = 8'd32;
    localparam logic [7:0] CARET_OFFSET   = 8'd64;
    localparam logic [7:0] PRINT_MAX      = 8'd126;
    localparam logic [7:0] HIGH_CTRL_MAX  = 8'd160;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

endpackage

### hdl/lnef_front.sv
// Front end: per-file state, squeeze and numbering decisions, byte classification.
module lnef_front
    import lnef_pkg::*;
#(
    parameter int DIGITS = 6
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  push,
    input  item_t                 item,
    input  logic                  q_full,
    output logic                  full,
    output logic                  q_wr,
    output cmd_t                  q_cmd,
    output logic [4*DIGITS-1:0]   q_digits
);

    localparam int LW = 4 * DIGITS;

    logic [LW-1:0] line_number_reg, line_number_next;
    logic          prev_nl_reg, prev_nl_next;
    logic [1:0]    blank_run_reg, blank_run_next;

    logic [LW-1:0] ln_cur, ln_bumped;
    logic          prev_cur;
    logic [1:0]    run_cur, run_sq;
    logic          accept, is_nl, sq_hit, drop, do_num;
    logic [7:0]    c;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign c      = item.in_byte;
    assign is_nl  = (c == CHAR_NL);

    // State as seen by this item, after a new-file reset
    always_comb
    begin
        ln_cur   = item.file_start ? LW'(1) : line_number_reg;
        prev_cur = item.file_start ? 1'b1 : prev_nl_reg;
        run_cur  = item.file_start ? 2'd0 : blank_run_reg;
    end

    // Squeeze: count newlines after a newline, saturating at two
    always_comb
    begin
        sq_hit = cfg.squeeze_blank && is_nl && prev_cur;
        run_sq = (run_cur == 2'd2) ? 2'd2 : run_cur + 2'd1;
        drop   = sq_hit && (run_sq == 2'd2);
    end

    // Numbering decision; non-blank mode wins
    always_comb
    begin
        if (cfg.number_nonblank)
        begin
            do_num = prev_cur && !is_nl;
        end
        else
        begin
            do_num = prev_cur && cfg.number_all;
        end
    end

    // BCD increment, holding at all nines
    always_comb
    begin
        logic       carry;
        logic       all9;
        logic [3:0] d;
        ln_bumped = ln_cur;
        carry     = 1'b1;
        all9      = 1'b1;
        for (int i = 0; i < DIGITS; i++)
        begin
            d = ln_cur[4*i +: 4];
            if (d != 4'd9)
            begin
                all9 = 1'b0;
            end
            if (carry)
            begin
                ln_bumped[4*i +: 4] = (d == 4'd9) ? 4'd0 : d + 4'd1;
                carry = (d == 4'd9);
            end
        end
        if (all9)
        begin
            ln_bumped = ln_cur;
        end
    end

    // Classify the body of the item
    always_comb
    begin
        q_cmd.do_num    = do_num;
        q_cmd.kind      = BODY_PLAIN;
        q_cmd.body_byte = c;
        if (cfg.show_tabs && c == CHAR_TAB)
        begin
            q_cmd.kind      = BODY_CARET;
            q_cmd.body_byte = CHAR_I;
        end
        else if (cfg.show_ends && is_nl)
        begin
            q_cmd.kind = BODY_DOLLAR;
        end
        else if (cfg.show_nonprinting
                 && (c < CHAR_TAB || (c > CHAR_NL && c < CTRL_LIMIT)))
        begin
            q_cmd.kind      = BODY_CARET;
            q_cmd.body_byte = c + CARET_OFFSET;
        end
        else if (cfg.show_nonprinting && c > PRINT_MAX && c <= HIGH_CTRL_MAX)
        begin
            q_cmd.kind      = BODY_CARET;
            q_cmd.body_byte = c - CARET_OFFSET;
        end
    end

    assign q_wr     = accept && !drop;
    assign q_digits = ln_cur;

    // Next state
    always_comb
    begin
        line_number_next = line_number_reg;
        prev_nl_next     = prev_nl_reg;
        blank_run_next   = blank_run_reg;
        if (accept)
        begin
            blank_run_next = sq_hit ? run_sq : 2'd0;
            if (drop)
            begin
                line_number_next = ln_cur;
                prev_nl_next     = prev_cur;
            end
            else
            begin
                line_number_next = do_num ? ln_bumped : ln_cur;
                prev_nl_next     = is_nl;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_number_reg <= LW'(1);
            prev_nl_reg     <= 1'b1;
            blank_run_reg   <= 2'd0;
        end
        else
        begin
            line_number_reg <= line_number_next;
            prev_nl_reg     <= prev_nl_next;
            blank_run_reg   <= blank_run_next;
        end
    end

endmodule

### hdl/lnef_queue.sv
// Short command queue between the front and the back.
module lnef_queue
    import lnef_pkg::*;
#(
    parameter int DIGITS = 6
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  cmd_t                wr_cmd,
    input  logic [4*DIGITS-1:0] wr_digits,
    input  logic                rd_en,
    output logic                q_full,
    output logic                q_ne,
    output cmd_t                rd_cmd,
    output logic [4*DIGITS-1:0] rd_digits
);

    localparam int LW = 4 * DIGITS;

    cmd_t          cmd_reg   [QUEUE_DEPTH];
    logic [LW-1:0] digit_reg [QUEUE_DEPTH];

    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;

    assign q_full    = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign q_ne      = (count_reg != '0);
    assign rd_cmd    = cmd_reg[rd_ptr_reg];
    assign rd_digits = digit_reg[rd_ptr_reg];

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + (QUEUE_AW+1)'(1);
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - (QUEUE_AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cmd_reg[wr_ptr_reg]   <= wr_cmd;
            digit_reg[wr_ptr_reg] <= wr_digits;
        end
    end

    a_no_read_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> q_ne)
        else $error("queue read while empty");

    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !q_full)
        else $error("queue written while full");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("queue fill count beyond depth");

endmodule

### hdl/lnef_back.sv
// Back end: spells out one command as a byte sequence into the result register.
module lnef_back
    import lnef_pkg::*;
#(
    parameter int DIGITS = 6
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_ne,
    input  cmd_t                q_cmd,
    input  logic [4*DIGITS-1:0] q_digits,
    output logic                q_rd,
    input  logic                pop,
    output logic                empty,
    output result_t             result
);

    localparam int PW = $clog2(DIGITS + 4);

    logic [PW-1:0] pos_reg, pos_next;
    logic          lead_reg, lead_next;
    logic          out_valid_reg, out_valid_next;
    result_t       out_item_reg;

    logic [PW-1:0] num_len, body_len, body_idx;
    logic          in_num, at_tab, lead_now, is_space, is_last, emit;
    logic [3:0]    digit;
    logic [7:0]    byte_val;

    assign empty  = !out_valid_reg;
    assign result = out_item_reg;

    // Layout of the current command
    always_comb
    begin
        num_len  = q_cmd.do_num ? PW'(DIGITS + 1) : '0;
        body_len = (q_cmd.kind == BODY_PLAIN) ? PW'(1) : PW'(2);
        body_idx = pos_reg - num_len;
        in_num   = q_cmd.do_num && (pos_reg < PW'(DIGITS));
        at_tab   = q_cmd.do_num && (pos_reg == PW'(DIGITS));
        is_last  = (pos_reg == num_len + body_len - PW'(1));
    end

    // Digit at the current position, most significant first
    always_comb
    begin
        digit = 4'd0;
        for (int i = 0; i < DIGITS; i++)
        begin
            if (pos_reg == PW'(DIGITS - 1 - i))
            begin
                digit = q_digits[4*i +: 4];
            end
        end
    end

    // Leading zeros become spaces, the units digit always shows
    always_comb
    begin
        lead_now = (pos_reg == '0) || lead_reg;
        is_space = lead_now && (digit == 4'd0) && (pos_reg != PW'(DIGITS - 1));
    end

    // Byte selection
    always_comb
    begin
        if (in_num)
        begin
            byte_val = is_space ? CHAR_SPACE : (CHAR_ZERO | {4'd0, digit});
        end
        else if (at_tab)
        begin
            byte_val = CHAR_TAB;
        end
        else
        begin
            case (q_cmd.kind)
                BODY_CARET:  byte_val = (body_idx == '0) ? CHAR_CARET : q_cmd.body_byte;
                BODY_DOLLAR: byte_val = (body_idx == '0) ? CHAR_DOLLAR : CHAR_NL;
                default:     byte_val = q_cmd.body_byte;
            endcase
        end
    end

    // Advance when the result register is free or being taken
    assign emit = q_ne && (!out_valid_reg || pop);
    assign q_rd = emit && is_last;

    always_comb
    begin
        pos_next       = pos_reg;
        lead_next      = lead_reg;
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            pos_next       = is_last ? '0 : pos_reg + PW'(1);
            if (in_num)
            begin
                lead_next = is_space;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            lead_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            lead_reg      <= lead_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_item_reg.out_byte <= byte_val;
            out_item_reg.last     <= is_last;
        end
    end

endmodule

### hdl/line_number_escape_filter.sv
// Top level of the line numbering and escape filter with its register port.
// Writes zero to NUMBER_DIGITS+3 result bytes for each byte item (line number
// field and tab, then the byte itself, its caret form or '$' and newline). The
// front accepts an item every cycle while its four-entry command queue has room;
// squeezed blank lines are absorbed there and give no result. The back produces
// one result byte per cycle while a command waits and the result register is
// free or being popped, so throughput is one item per cycle for items that give
// one byte; a longer item holds the back until its last byte is out. An
// accepted item passes the queue, then the result register, before its first
// result byte shows. Registers sit at byte addresses 0, 4, ... 20; only bit 0 of
// each is kept, and each should be written only while no item is in flight.
module line_number_escape_filter
    import lnef_pkg::*;
#(
    parameter int NUMBER_DIGITS = 6
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Item side
    input  logic        push,
    output logic        full,
    input  item_t       item,
    // Result side
    output logic        empty,
    input  logic        pop,
    output result_t     result,
    // Register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LW = 4 * NUMBER_DIGITS;

    cfg_t          cfg_reg, cfg_next;
    logic [2:0]    reg_idx;
    logic          wr_hit;
    logic          rd_bit;

    logic          q_full, q_ne, q_wr, q_rd;
    cmd_t          wr_cmd, rd_cmd;
    logic [LW-1:0] wr_digits, rd_digits;

    // Register port
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_hit  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_hit)
        begin
            unique case (reg_idx)
                REG_NUMBER_NONBLANK:  cfg_next.number_nonblank  = pwdata[0];
                REG_NUMBER_ALL:       cfg_next.number_all       = pwdata[0];
                REG_SQUEEZE_BLANK:    cfg_next.squeeze_blank    = pwdata[0];
                REG_SHOW_ENDS:        cfg_next.show_ends        = pwdata[0];
                REG_SHOW_TABS:        cfg_next.show_tabs        = pwdata[0];
                REG_SHOW_NONPRINTING: cfg_next.show_nonprinting = pwdata[0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_NUMBER_NONBLANK:  rd_bit = cfg_reg.number_nonblank;
            REG_NUMBER_ALL:       rd_bit = cfg_reg.number_all;
            REG_SQUEEZE_BLANK:    rd_bit = cfg_reg.squeeze_blank;
            REG_SHOW_ENDS:        rd_bit = cfg_reg.show_ends;
            REG_SHOW_TABS:        rd_bit = cfg_reg.show_tabs;
            REG_SHOW_NONPRINTING: rd_bit = cfg_reg.show_nonprinting;
            default:              rd_bit = 1'b0;
        endcase
    end

    assign prdata = {31'd0, rd_bit};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: state and classification
    lnef_front #(
        .DIGITS (NUMBER_DIGITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .push     (push),
        .item     (item),
        .q_full   (q_full),
        .full     (full),
        .q_wr     (q_wr),
        .q_cmd    (wr_cmd),
        .q_digits (wr_digits)
    );

    // Command queue
    lnef_queue #(
        .DIGITS (NUMBER_DIGITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (q_wr),
        .wr_cmd    (wr_cmd),
        .wr_digits (wr_digits),
        .rd_en     (q_rd),
        .q_full    (q_full),
        .q_ne      (q_ne),
        .rd_cmd    (rd_cmd),
        .rd_digits (rd_digits)
    );

    // Back: byte sequencer and result register
    lnef_back #(
        .DIGITS (NUMBER_DIGITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_ne     (q_ne),
        .q_cmd    (rd_cmd),
        .q_digits (rd_digits),
        .q_rd     (q_rd),
        .pop      (pop),
        .empty    (empty),
        .result   (result)
    );

endmodule
